>>> hdl/ppm_gen_pkg.sv
// ----------------------------------------------------------------------------
// ppm_gen_pkg
// shared types and constants of the ppm frame generator
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_gen_pkg;

    // default number of channel slots in each store
    localparam int MAX_CHANNELS_DEF = 16;

    // register reset values
    localparam logic [15:0] SYNC_PERIOD_RST = 16'd350;
    localparam logic [15:0] GAP_TICKS_RST   = 16'd300;

    // configuration register indexes
    localparam int          CFG_INDEX_W     = 8;
    localparam logic [7:0]  REG_SYNC_PERIOD = 8'd0;
    localparam logic [7:0]  REG_GAP_TICKS   = 8'd1;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // one result item
    typedef struct packed {
        logic ppm_level;
        logic frame_active;
        logic write_overflow;
    } result_t;

    // store controls from the sequencer
    typedef struct packed {
        logic wr_en;
        logic copy_en;
    } store_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/ppm_gen_store.sv
// ----------------------------------------------------------------------------
// ppm_gen_store
// pending and frame channel stores, frame snapshot and slot read
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_gen_store #(
    parameter int MAX_CHANNELS = ppm_gen_pkg::MAX_CHANNELS_DEF,
    parameter int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  wire                       clk,
    input  ppm_gen_pkg::store_ctrl_t  ctrl,
    input  wire [IDX_W-1:0]           wr_addr,
    input  wire [15:0]                wr_data,
    input  wire [IDX_W-1:0]           rd_addr,
    output logic [15:0]               rd_data
);

    logic [15:0] pend_reg  [MAX_CHANNELS];
    logic [15:0] frame_reg [MAX_CHANNELS];

    // pending store takes one value per write
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            pend_reg[wr_addr] <= wr_data;
        end
    end

    // snapshot includes the value written in the same transfer
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            if (ctrl.copy_en)
            begin
                if (ctrl.wr_en && (wr_addr == IDX_W'(i)))
                begin
                    frame_reg[i] <= wr_data;
                end
                else
                begin
                    frame_reg[i] <= pend_reg[i];
                end
            end
        end
    end

    assign rd_data = frame_reg[rd_addr];

endmodule

`default_nettype wire

>>> hdl/ppm_gen_outbuf.sv
// ----------------------------------------------------------------------------
// ppm_gen_outbuf
// two-entry result buffer between the sequencer and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_gen_outbuf (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  ppm_gen_pkg::result_t  push_data,
    output logic                  full,
    output logic                  res_valid,
    input  wire                   res_stall,
    output ppm_gen_pkg::result_t  res_data
);

    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    ppm_gen_pkg::result_t head_reg;
    ppm_gen_pkg::result_t skid_reg;
    logic                 pop;

    assign pop       = (count_reg != 2'd0) && !res_stall;
    assign full      = (count_reg == 2'd2);
    assign res_valid = (count_reg != 2'd0);
    assign res_data  = head_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // payload moves without reset
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (count_reg == 2'd2)
            begin
                head_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= push_data;
                end
            end
            else if (push)
            begin
                head_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                head_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/ppm_frame_generator.sv
// ----------------------------------------------------------------------------
// ppm_frame_generator
// pulse position modulation frame generator driven by timer ticks
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_type, channel_value, last_channel
// res       out        res_valid / res_stall  ppm_level, frame_active, write_overflow
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request transfer per clock while req_stall is low; each result is registered in the result buffer
// the sequencer updates all state in the cycle of the transfer, so the rate is set
// by the two-entry result buffer only: req_stall rises when both entries wait
// reset clears the counters, the busy flag and the registers to their defaults;
// the channel stores hold no reset and are never read before being written
// cfg_ready is always high; configuration takes effect for the next transfer
//
`default_nettype none

module ppm_frame_generator #(
    parameter int MAX_CHANNELS = ppm_gen_pkg::MAX_CHANNELS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // request channel
    input  wire         req_valid,
    output logic        req_stall,
    input  wire         req_type,
    input  wire  [15:0] channel_value,
    input  wire         last_channel,
    // result channel
    output logic        res_valid,
    input  wire         res_stall,
    output logic        ppm_level,
    output logic        frame_active,
    output logic        write_overflow,
    // configuration channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [ppm_gen_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [15:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // configuration registers
    logic [15:0] sync_period_reg;
    logic [15:0] gap_ticks_reg;

    // sequencer state
    logic [CNT_W-1:0] wpos_reg,   wpos_next;
    logic [CNT_W-1:0] fcount_reg, fcount_next;
    logic [CNT_W-1:0] slot_reg,   slot_next;
    logic [15:0]      tick_reg,   tick_next;
    logic             busy_reg,   busy_next;

    logic                      accept;
    logic                      buf_full;
    logic [15:0]               frame_rd;
    logic [15:0]               period;
    logic [15:0]               high_time;
    logic                      level_cur;
    logic                      sync_high;
    logic                      room;
    logic                      start;
    logic [CNT_W-1:0]          slot_m1;
    ppm_gen_pkg::store_ctrl_t  sctrl;
    ppm_gen_pkg::result_t      result;
    ppm_gen_pkg::result_t      res_data;

    assign cfg_ready = 1'b1;
    assign req_stall = buf_full;
    assign accept    = req_valid && !buf_full;

    // configuration writes, unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_period_reg <= ppm_gen_pkg::SYNC_PERIOD_RST;
            gap_ticks_reg   <= ppm_gen_pkg::GAP_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ppm_gen_pkg::REG_SYNC_PERIOD)
            begin
                sync_period_reg <= cfg_data;
            end
            else if (cfg_index == ppm_gen_pkg::REG_GAP_TICKS)
            begin
                gap_ticks_reg <= cfg_data;
            end
        end
    end

    // period of the current pulse: sync slot first, then one slot per channel
    assign slot_m1   = slot_reg - CNT_W'(1);
    assign period    = (slot_reg == '0) ? sync_period_reg : frame_rd;
    assign high_time = (period > gap_ticks_reg) ? (period - gap_ticks_reg) : 16'd0;
    assign level_cur = busy_reg && (tick_reg < high_time);
    // a fresh frame sits at tick zero of the sync pulse
    assign sync_high = (sync_period_reg > gap_ticks_reg);

    assign room  = (wpos_reg < CNT_W'(MAX_CHANNELS));
    assign start = accept && (req_type == ppm_gen_pkg::REQ_WRITE) && last_channel && !busy_reg;

    assign sctrl.wr_en   = accept && (req_type == ppm_gen_pkg::REQ_WRITE) && room;
    assign sctrl.copy_en = start;

    always_comb
    begin
        wpos_next   = wpos_reg;
        fcount_next = fcount_reg;
        slot_next   = slot_reg;
        tick_next   = tick_reg;
        busy_next   = busy_reg;
        result      = '0;
        if (accept)
        begin
            if (req_type == ppm_gen_pkg::REQ_TICK)
            begin
                result.ppm_level    = level_cur;
                result.frame_active = busy_reg;
                if (busy_reg)
                begin
                    if (tick_reg >= period)
                    begin
                        tick_next = 16'd0;
                        if (slot_reg >= fcount_reg)
                        begin
                            busy_next = 1'b0;
                            slot_next = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        tick_next = tick_reg + 16'd1;
                    end
                end
            end
            else
            begin
                // channel write, dropped when the pending store is full
                if (room)
                begin
                    wpos_next = wpos_reg + CNT_W'(1);
                end
                result.write_overflow = !room;
                if (last_channel)
                begin
                    wpos_next = '0;
                    if (!busy_reg)
                    begin
                        fcount_next = room ? (wpos_reg + CNT_W'(1)) : wpos_reg;
                        slot_next   = '0;
                        tick_next   = 16'd0;
                        busy_next   = 1'b1;
                    end
                end
                result.frame_active = busy_reg || start;
                result.ppm_level    = start ? sync_high : level_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg   <= '0;
            fcount_reg <= '0;
            slot_reg   <= '0;
            tick_reg   <= 16'd0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            wpos_reg   <= wpos_next;
            fcount_reg <= fcount_next;
            slot_reg   <= slot_next;
            tick_reg   <= tick_next;
            busy_reg   <= busy_next;
        end
    end

    ppm_gen_store #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_store (
        .clk     (clk),
        .ctrl    (sctrl),
        .wr_addr (wpos_reg[IDX_W-1:0]),
        .wr_data (channel_value),
        .rd_addr (slot_m1[IDX_W-1:0]),
        .rd_data (frame_rd)
    );

    ppm_gen_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .full      (buf_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    assign ppm_level      = res_data.ppm_level;
    assign frame_active   = res_data.frame_active;
    assign write_overflow = res_data.write_overflow;

endmodule

`default_nettype wire

>>> hdl/ppm_gen_chk.sv
// ----------------------------------------------------------------------------
// ppm_gen_chk
// port checker for the ppm frame generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_gen_chk (
    input wire clk,
    input wire rst_n,
    input wire req_valid,
    input wire req_stall,
    input wire res_valid,
    input wire res_stall,
    input wire ppm_level,
    input wire frame_active,
    input wire write_overflow
);

    // a waiting result is not withdrawn
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its fields
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(ppm_level) && $stable(frame_active)
            && $stable(write_overflow))
        else $error("result changed while stalled");

    // the request side only stalls when results are waiting
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_valid)
        else $error("request stalled with no result pending");

    // a result never appears without a request transfer before it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !$past(res_valid) |-> $past(req_valid && !req_stall))
        else $error("result without a request transfer");

    // the pin is only high inside a frame
    a_level_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(ppm_level && !frame_active))
        else $error("pin high outside a frame");

endmodule

bind ppm_frame_generator ppm_gen_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .ppm_level      (ppm_level),
    .frame_active   (frame_active),
    .write_overflow (write_overflow)
);

`default_nettype wire
